// ===== src/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// scsa_pkg
// shared constants, codes and types of the size class slot allocator
// ----------------------------------------------------------------------------
package scsa_pkg;

  // defaults of the top level parameters
  localparam int unsigned SLOTS_PER_BATCH = 8;
  localparam int unsigned MAX_BATCHES     = 4;
  localparam int unsigned NUM_CLASSES     = 5;

  // granule size is fixed: class c serves slots of c granules
  localparam int unsigned GRANULE_BYTES = 16;
  localparam int unsigned GRANULE_SHIFT = 4;

  // depth of the queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  // port field widths
  localparam int unsigned SIZE_W     = 8;
  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned BATCH_W    = 2;
  localparam int unsigned OFFSET_W   = 10;
  localparam int unsigned STATUS_W   = 3;
  // widest slot index (up to 16 slots per batch) and class index (up to 8 classes)
  localparam int unsigned SLOT_IDX_W = 4;
  localparam int unsigned CLS_IDX_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_BATCH  = 3'd2,
    ST_NOT_START = 3'd3,
    ST_DOUBLE    = 3'd4,
    ST_OUTSIDE   = 3'd5
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REJECT
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC
  } back_state_e;

  // classified request handed from front to back
  typedef struct packed {
    op_e                   op;
    logic [CLS_IDX_W-1:0]  cls_idx;
    logic [BATCH_W-1:0]    batch;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  misaligned;
    status_e               status;
  } cmd_t;

endpackage

// ===== src/scsa_front.sv =====
// ----------------------------------------------------------------------------
// scsa_front
// classifies a request: size to class, free range and alignment checks
// ----------------------------------------------------------------------------
module scsa_front #(
  parameter int unsigned SLOTS_PER_BATCH = scsa_pkg::SLOTS_PER_BATCH,
  parameter int unsigned NUM_CLASSES     = scsa_pkg::NUM_CLASSES
) (
  input  logic                              kind_i,
  input  logic [scsa_pkg::SIZE_W-1:0]       request_size_i,
  input  logic [scsa_pkg::CLASS_W-1:0]      free_class_i,
  input  logic [scsa_pkg::BATCH_W-1:0]      free_batch_i,
  input  logic [scsa_pkg::OFFSET_W-1:0]     free_offset_i,
  output scsa_pkg::cmd_t                    cmd_o
);

  localparam int unsigned OFF_HI_W = scsa_pkg::OFFSET_W - scsa_pkg::GRANULE_SHIFT;

  logic [scsa_pkg::SIZE_W:0]           size_sum;
  logic [4:0]                          alloc_cls;
  logic [OFF_HI_W-1:0]                 off_hi;
  logic [7:0]                          span;
  logic [6:0]                          prod;
  logic                                hit;
  logic [scsa_pkg::SLOT_IDX_W-1:0]     hit_slot;

  always_comb begin
    size_sum  = {1'b0, request_size_i} + 9'(scsa_pkg::GRANULE_BYTES - 1);
    alloc_cls = 5'(size_sum >> scsa_pkg::GRANULE_SHIFT);
    off_hi    = free_offset_i[scsa_pkg::OFFSET_W-1:scsa_pkg::GRANULE_SHIFT];
    // granules in one batch of this class
    span      = 8'(SLOTS_PER_BATCH) * {5'b0, free_class_i};

    // slot k starts at k * class granules
    hit      = 1'b0;
    hit_slot = '0;
    prod     = '0;
    for (int k = 0; k < SLOTS_PER_BATCH; k++) begin
      prod = 7'(k) * {4'b0, free_class_i};
      if (!hit && prod == {1'b0, off_hi}) begin
        hit      = 1'b1;
        hit_slot = scsa_pkg::SLOT_IDX_W'(k);
      end
    end

    cmd_o        = '0;
    cmd_o.status = scsa_pkg::ST_OK;
    if (kind_i == scsa_pkg::KIND_ALLOC) begin
      if (request_size_i == '0 || alloc_cls > 5'(NUM_CLASSES)) begin
        cmd_o.op     = scsa_pkg::OP_REJECT;
        cmd_o.status = scsa_pkg::ST_BAD_SIZE;
      end else begin
        cmd_o.op      = scsa_pkg::OP_ALLOC;
        cmd_o.cls_idx = 3'(alloc_cls - 5'd1);
      end
    end else begin
      if (free_class_i == '0 || {1'b0, free_class_i} > 4'(NUM_CLASSES)) begin
        cmd_o.op     = scsa_pkg::OP_REJECT;
        cmd_o.status = scsa_pkg::ST_OUTSIDE;
      end else if ({2'b0, off_hi} >= span) begin
        cmd_o.op     = scsa_pkg::OP_REJECT;
        cmd_o.status = scsa_pkg::ST_OUTSIDE;
      end else begin
        cmd_o.op         = scsa_pkg::OP_FREE;
        cmd_o.cls_idx    = free_class_i - 3'd1;
        cmd_o.batch      = free_batch_i;
        cmd_o.slot       = hit_slot;
        cmd_o.misaligned = (free_offset_i[scsa_pkg::GRANULE_SHIFT-1:0] != '0) || !hit;
      end
    end
  end

endmodule

// ===== src/scsa_fifo.sv =====
// ----------------------------------------------------------------------------
// scsa_fifo
// small queue of classified requests between front and back
// ----------------------------------------------------------------------------
module scsa_fifo #(
  parameter int unsigned DEPTH = scsa_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scsa_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output scsa_pkg::cmd_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  scsa_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/scsa_back.sv =====
// ----------------------------------------------------------------------------
// scsa_back
// executes requests against the per-class bitmaps and holds the result
// ----------------------------------------------------------------------------
module scsa_back #(
  parameter int unsigned SLOTS_PER_BATCH = scsa_pkg::SLOTS_PER_BATCH,
  parameter int unsigned MAX_BATCHES     = scsa_pkg::MAX_BATCHES,
  parameter int unsigned NUM_CLASSES     = scsa_pkg::NUM_CLASSES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  scsa_pkg::cmd_t                 cmd_i,
  output logic                           cmd_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [scsa_pkg::STATUS_W-1:0]  status_o,
  output logic [scsa_pkg::CLASS_W-1:0]   granted_class_o,
  output logic [scsa_pkg::BATCH_W-1:0]   granted_batch_o,
  output logic [scsa_pkg::OFFSET_W-1:0]  granted_offset_o
);

  localparam int unsigned MAP_W  = SLOTS_PER_BATCH * MAX_BATCHES;
  localparam int unsigned CNT_W  = $clog2(MAX_BATCHES + 1);
  localparam int unsigned BIDX_W = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
  localparam int unsigned SIDX_W = (SLOTS_PER_BATCH > 1) ? $clog2(SLOTS_PER_BATCH) : 1;
  localparam int unsigned CI_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  scsa_pkg::back_state_e state_q, state_d;
  scsa_pkg::cmd_t        cmd_q;
  logic [MAP_W-1:0]      map_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [MAP_W-1:0]      free_map_q [NUM_CLASSES];
  logic [CNT_W-1:0]      batch_cnt_q [NUM_CLASSES];
  logic [CI_W-1:0]       ci;

  logic                           out_valid_q;
  scsa_pkg::status_e              status_q;
  logic [scsa_pkg::CLASS_W-1:0]   class_q;
  logic [scsa_pkg::BATCH_W-1:0]   batch_q;
  logic [scsa_pkg::OFFSET_W-1:0]  offset_q;

  logic                  load_out;
  logic [MAP_W-1:0]      eff_map, new_map;
  logic [CNT_W-1:0]      cnt_eff, new_cnt;
  logic                  found, cur_bit, wr_en;
  logic [BIDX_W-1:0]     sel_b, tb;
  logic [SIDX_W-1:0]     ts;
  logic [SIDX_W-1:0]     low_slot [MAX_BATCHES];
  logic                  low_hit;
  logic [3:0]            cls_num;
  logic [11:0]           off_full;
  scsa_pkg::status_e              res_status;
  logic [scsa_pkg::CLASS_W-1:0]   res_class;
  logic [scsa_pkg::BATCH_W-1:0]   res_batch;
  logic [scsa_pkg::OFFSET_W-1:0]  res_offset;

  assign ci       = cmd_q.cls_idx[CI_W-1:0];
  assign load_out = (state_q == scsa_pkg::S_EXEC) && (!out_valid_q || out_ready_i);

  // sequencer: take a request, read its class, execute and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      scsa_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = scsa_pkg::S_LOAD;
        end
      end
      scsa_pkg::S_LOAD: begin
        state_d = scsa_pkg::S_EXEC;
      end
      scsa_pkg::S_EXEC: begin
        if (load_out) begin
          state_d = scsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = scsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == scsa_pkg::S_LOAD) begin
      map_q <= free_map_q[ci];
      cnt_q <= batch_cnt_q[ci];
    end
  end

  // execute step
  always_comb begin
    // a class without batches gets its first one on allocate
    eff_map = map_q;
    cnt_eff = cnt_q;
    if (cnt_q == '0) begin
      eff_map[SLOTS_PER_BATCH-1:0] = '1;
      cnt_eff = CNT_W'(1);
    end

    // lowest free slot of each batch, then the lowest batch holding one
    for (int b = 0; b < MAX_BATCHES; b++) begin
      low_hit     = 1'b0;
      low_slot[b] = '0;
      for (int s = 0; s < SLOTS_PER_BATCH; s++) begin
        if (!low_hit && eff_map[b*SLOTS_PER_BATCH + s]) begin
          low_hit     = 1'b1;
          low_slot[b] = SIDX_W'(s);
        end
      end
    end
    found = 1'b0;
    sel_b = '0;
    for (int b = 0; b < MAX_BATCHES; b++) begin
      if (!found && CNT_W'(b) < cnt_eff &&
          |eff_map[b*SLOTS_PER_BATCH +: SLOTS_PER_BATCH]) begin
        found = 1'b1;
        sel_b = BIDX_W'(b);
      end
    end

    tb         = '0;
    ts         = '0;
    wr_en      = 1'b0;
    new_cnt    = cnt_q;
    new_map    = eff_map;
    res_status = scsa_pkg::ST_OK;
    res_class  = '0;
    res_batch  = '0;
    res_offset = '0;
    cls_num    = {1'b0, cmd_q.cls_idx} + 4'd1;
    cur_bit    = 1'b0;
    off_full   = '0;

    unique case (cmd_q.op)
      scsa_pkg::OP_ALLOC: begin
        if (found) begin
          tb      = sel_b;
          ts      = low_slot[sel_b];
          wr_en   = 1'b1;
          new_cnt = cnt_eff;
        end else if (cnt_eff >= CNT_W'(MAX_BATCHES)) begin
          res_status = scsa_pkg::ST_NO_BATCH;
        end else begin
          // append a batch and take its first slot
          tb      = BIDX_W'(cnt_eff);
          ts      = '0;
          wr_en   = 1'b1;
          new_cnt = cnt_eff + CNT_W'(1);
          for (int b = 0; b < MAX_BATCHES; b++) begin
            if (BIDX_W'(b) == tb) begin
              new_map[b*SLOTS_PER_BATCH +: SLOTS_PER_BATCH] = '1;
            end
          end
        end
        if (wr_en) begin
          for (int b = 0; b < MAX_BATCHES; b++) begin
            for (int s = 0; s < SLOTS_PER_BATCH; s++) begin
              if (BIDX_W'(b) == tb && SIDX_W'(s) == ts) begin
                new_map[b*SLOTS_PER_BATCH + s] = 1'b0;
              end
            end
          end
          off_full   = (12'(ts) * 12'(cls_num)) << scsa_pkg::GRANULE_SHIFT;
          res_class  = cls_num[scsa_pkg::CLASS_W-1:0];
          res_batch  = scsa_pkg::BATCH_W'(tb);
          res_offset = off_full[scsa_pkg::OFFSET_W-1:0];
        end
      end
      scsa_pkg::OP_FREE: begin
        tb = BIDX_W'(cmd_q.batch);
        ts = SIDX_W'(cmd_q.slot);
        for (int b = 0; b < MAX_BATCHES; b++) begin
          for (int s = 0; s < SLOTS_PER_BATCH; s++) begin
            if (BIDX_W'(b) == tb && SIDX_W'(s) == ts) begin
              cur_bit = map_q[b*SLOTS_PER_BATCH + s];
            end
          end
        end
        new_map = map_q;
        if (4'(cmd_q.batch) >= 4'(cnt_q)) begin
          res_status = scsa_pkg::ST_OUTSIDE;
        end else if (cmd_q.misaligned) begin
          res_status = scsa_pkg::ST_NOT_START;
        end else if (cur_bit) begin
          res_status = scsa_pkg::ST_DOUBLE;
        end else begin
          wr_en = 1'b1;
          for (int b = 0; b < MAX_BATCHES; b++) begin
            for (int s = 0; s < SLOTS_PER_BATCH; s++) begin
              if (BIDX_W'(b) == tb && SIDX_W'(s) == ts) begin
                new_map[b*SLOTS_PER_BATCH + s] = 1'b1;
              end
            end
          end
        end
      end
      scsa_pkg::OP_REJECT: begin
        res_status = cmd_q.status;
      end
      default: begin
        res_status = cmd_q.status;
      end
    endcase
  end

  // class state: all slots free, class 1 owns one batch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_map_q[c]  <= '1;
        batch_cnt_q[c] <= (c == 0) ? CNT_W'(1) : '0;
      end
    end else if (load_out && wr_en) begin
      free_map_q[ci]  <= new_map;
      batch_cnt_q[ci] <= new_cnt;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= res_status;
      class_q  <= res_class;
      batch_q  <= res_batch;
      offset_q <= res_offset;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_class_o  = class_q;
  assign granted_batch_o  = batch_q;
  assign granted_offset_o = offset_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && wr_en) |-> (new_cnt <= CNT_W'(MAX_BATCHES) && new_cnt != '0))
    else $error("batch count out of range on write back");

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (out_valid_q && state_q == scsa_pkg::S_IDLE))
    else $error("executed request did not produce a result");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != scsa_pkg::ST_OK) |->
      (class_q == '0 && batch_q == '0 && offset_q == '0))
    else $error("failed request carries a grant");

  a_free_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && wr_en && cmd_q.op == scsa_pkg::OP_FREE) |->
      ($countones(new_map) == $countones(map_q) + 1))
    else $error("free changed more than one slot");

endmodule

// ===== src/size_class_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// size_class_slot_allocator_core
// flow: a request taken into the queue is popped by the back end sequencer in idle,
//   its class bitmap is read in load, and in exec it executes, writes back and fills
//   the output register once that register is free
// the back end takes a new request only after the previous one has left exec
// reset: every slot free, class 1 owns one batch, other classes none
// ----------------------------------------------------------------------------
module size_class_slot_allocator_core #(
  parameter int unsigned SLOTS_PER_BATCH = scsa_pkg::SLOTS_PER_BATCH,
  parameter int unsigned MAX_BATCHES     = scsa_pkg::MAX_BATCHES,
  parameter int unsigned NUM_CLASSES     = scsa_pkg::NUM_CLASSES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [scsa_pkg::SIZE_W-1:0]    request_size_i,
  input  logic [scsa_pkg::CLASS_W-1:0]   free_class_i,
  input  logic [scsa_pkg::BATCH_W-1:0]   free_batch_i,
  input  logic [scsa_pkg::OFFSET_W-1:0]  free_offset_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [scsa_pkg::STATUS_W-1:0]  status_o,
  output logic [scsa_pkg::CLASS_W-1:0]   granted_class_o,
  output logic [scsa_pkg::BATCH_W-1:0]   granted_batch_o,
  output logic [scsa_pkg::OFFSET_W-1:0]  granted_offset_o
);

  // front: size rounding, class range, free offset range and alignment
  scsa_pkg::cmd_t front_cmd;
  scsa_pkg::cmd_t queue_cmd;
  logic           queue_full;
  logic           queue_valid;
  logic           queue_pop;
  logic           push;

  // the request is taken whenever the queue has room, even while a
  // result still waits in the output register
  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && in_ready_o;

  scsa_front #(
    .SLOTS_PER_BATCH (SLOTS_PER_BATCH),
    .NUM_CLASSES     (NUM_CLASSES)
  ) u_front (
    .kind_i         (kind_i),
    .request_size_i (request_size_i),
    .free_class_i   (free_class_i),
    .free_batch_i   (free_batch_i),
    .free_offset_i  (free_offset_i),
    .cmd_o          (front_cmd)
  );

  // queue decouples front acceptance from back end execution
  scsa_fifo #(
    .DEPTH (scsa_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  // back: bitmap search and update, batch append, double free check,
  // result register toward the result channel
  scsa_back #(
    .SLOTS_PER_BATCH (SLOTS_PER_BATCH),
    .MAX_BATCHES     (MAX_BATCHES),
    .NUM_CLASSES     (NUM_CLASSES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (queue_valid),
    .cmd_i            (queue_cmd),
    .cmd_pop_o        (queue_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .granted_class_o  (granted_class_o),
    .granted_batch_o  (granted_batch_o),
    .granted_offset_o (granted_offset_o)
  );

endmodule

// ===== tb/tb_size_class_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_slot_allocator_core
// self-checking bench for the slab slot allocator: every accepted request is
// run through a bitmap model of the classes, and each result is compared with
// the oldest predicted grant. directed corner cases come first, then random
// traffic under three idling mixes and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_size_class_slot_allocator_core;

  localparam int unsigned SLOTS_PER_CLASS = scsa_pkg::MAX_BATCHES * scsa_pkg::SLOTS_PER_BATCH;
  localparam int unsigned PHASE_ITEMS     = 275;
  localparam int unsigned HOLD_CYCLES     = 300;

  typedef struct packed {
    scsa_pkg::status_e                status;
    logic [scsa_pkg::CLASS_W-1:0]     cls;
    logic [scsa_pkg::BATCH_W-1:0]     batch;
    logic [scsa_pkg::OFFSET_W-1:0]    offset;
  } grant_t;

  // bitmap model of the allocator plus the queue of grants still to come out
  class slab_scoreboard;
    logic [SLOTS_PER_CLASS-1:0] slot_free [scsa_pkg::NUM_CLASSES];
    int unsigned                batches   [scsa_pkg::NUM_CLASSES];
    grant_t                     pending_grants [$];
    int                         errors;

    function new();
      errors = 0;
      foreach (slot_free[i]) begin
        slot_free[i] = '1;
        batches[i]   = (i == 0) ? 1 : 0;
      end
    endfunction

    function void open_batch(int unsigned ci);
      for (int k = 0; k < scsa_pkg::SLOTS_PER_BATCH; k++)
        slot_free[ci][batches[ci] * scsa_pkg::SLOTS_PER_BATCH + k] = 1'b1;
      batches[ci]++;
    endfunction

    function grant_t grant_slot(int unsigned size);
      grant_t      g;
      int unsigned cls, ci, used, pos, bidx, boff;
      g = '0;
      if (size == 0) begin
        g.status = scsa_pkg::ST_BAD_SIZE;
        return g;
      end
      cls = (size + scsa_pkg::GRANULE_BYTES - 1) / scsa_pkg::GRANULE_BYTES;
      if (cls > scsa_pkg::NUM_CLASSES) begin
        g.status = scsa_pkg::ST_BAD_SIZE;
        return g;
      end
      ci = cls - 1;
      if (batches[ci] == 0) open_batch(ci);
      used = batches[ci] * scsa_pkg::SLOTS_PER_BATCH;
      // lowest free slot among the batches the class owns
      pos = used;
      for (int p = int'(used) - 1; p >= 0; p--)
        if (slot_free[ci][p]) pos = p;
      if (pos == used) begin
        if (batches[ci] >= scsa_pkg::MAX_BATCHES) begin
          g.status = scsa_pkg::ST_NO_BATCH;
          return g;
        end
        open_batch(ci);
      end
      slot_free[ci][pos] = 1'b0;
      bidx     = pos / scsa_pkg::SLOTS_PER_BATCH;
      boff     = (pos % scsa_pkg::SLOTS_PER_BATCH) * cls * scsa_pkg::GRANULE_BYTES;
      g.status = scsa_pkg::ST_OK;
      g.cls    = cls[scsa_pkg::CLASS_W-1:0];
      g.batch  = bidx[scsa_pkg::BATCH_W-1:0];
      g.offset = boff[scsa_pkg::OFFSET_W-1:0];
      return g;
    endfunction

    function grant_t release_slot(int unsigned cls, int unsigned batch, int unsigned off);
      grant_t      g;
      int unsigned ci, slot_bytes, pos;
      g = '0;
      if (cls == 0 || cls > scsa_pkg::NUM_CLASSES) begin
        g.status = scsa_pkg::ST_OUTSIDE;
        return g;
      end
      ci         = cls - 1;
      slot_bytes = cls * scsa_pkg::GRANULE_BYTES;
      if (batch >= batches[ci] || off >= scsa_pkg::SLOTS_PER_BATCH * slot_bytes) begin
        g.status = scsa_pkg::ST_OUTSIDE;
        return g;
      end
      if (off % slot_bytes != 0) begin
        g.status = scsa_pkg::ST_NOT_START;
        return g;
      end
      pos = batch * scsa_pkg::SLOTS_PER_BATCH + off / slot_bytes;
      if (slot_free[ci][pos]) begin
        g.status = scsa_pkg::ST_DOUBLE;
        return g;
      end
      slot_free[ci][pos] = 1'b1;
      g.status = scsa_pkg::ST_OK;
      return g;
    endfunction

    function void note_request(scsa_pkg::kind_e kind, int unsigned size, int unsigned cls,
                               int unsigned batch, int unsigned off);
      if (kind == scsa_pkg::KIND_ALLOC) pending_grants.push_back(grant_slot(size));
      else pending_grants.push_back(release_slot(cls, batch, off));
    endfunction

    function void check_result(logic [scsa_pkg::STATUS_W-1:0] st,
                               logic [scsa_pkg::CLASS_W-1:0] c,
                               logic [scsa_pkg::BATCH_W-1:0] b,
                               logic [scsa_pkg::OFFSET_W-1:0] o);
      grant_t exp_g;
      if (pending_grants.size() == 0) begin
        $error("unexpected result: status %0d class %0d batch %0d offset %0d", st, c, b, o);
        errors++;
        return;
      end
      exp_g = pending_grants.pop_front();
      if (exp_g.status !== st) begin
        $error("status: expected %0d, got %0d", exp_g.status, st);
        errors++;
      end
      if (exp_g.cls !== c) begin
        $error("granted_class: expected %0d, got %0d", exp_g.cls, c);
        errors++;
      end
      if (exp_g.batch !== b) begin
        $error("granted_batch: expected %0d, got %0d", exp_g.batch, b);
        errors++;
      end
      if (exp_g.offset !== o) begin
        $error("granted_offset: expected %0d, got %0d", exp_g.offset, o);
        errors++;
      end
    endfunction

    // random slot of an existing batch that is taken (want_free 0) or free (1)
    function bit pick_slot(bit want_free, output int unsigned cls,
                           output int unsigned batch, output int unsigned off);
      int unsigned c0, p0, c, p;
      c0 = $urandom_range(scsa_pkg::NUM_CLASSES - 1);
      p0 = $urandom_range(SLOTS_PER_CLASS - 1);
      cls = 0; batch = 0; off = 0;
      for (int i = 0; i < scsa_pkg::NUM_CLASSES; i++) begin
        c = (c0 + i) % scsa_pkg::NUM_CLASSES;
        for (int j = 0; j < SLOTS_PER_CLASS; j++) begin
          p = (p0 + j) % SLOTS_PER_CLASS;
          if (p < batches[c] * scsa_pkg::SLOTS_PER_BATCH && slot_free[c][p] == want_free) begin
            cls   = c + 1;
            batch = p / scsa_pkg::SLOTS_PER_BATCH;
            off   = (p % scsa_pkg::SLOTS_PER_BATCH) * cls * scsa_pkg::GRANULE_BYTES;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready_o;
  logic                          kind_q;
  logic [scsa_pkg::SIZE_W-1:0]   size_q;
  logic [scsa_pkg::CLASS_W-1:0]  free_class_q;
  logic [scsa_pkg::BATCH_W-1:0]  free_batch_q;
  logic [scsa_pkg::OFFSET_W-1:0] free_offset_q;
  logic                          out_valid_o;
  logic                          out_ready;
  logic [scsa_pkg::STATUS_W-1:0] status_o;
  logic [scsa_pkg::CLASS_W-1:0]  granted_class_o;
  logic [scsa_pkg::BATCH_W-1:0]  granted_batch_o;
  logic [scsa_pkg::OFFSET_W-1:0] granted_offset_o;

  slab_scoreboard sb;
  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;
  bit             hold_go;
  int unsigned    burst_left;
  int unsigned    burst_cls;

  size_class_slot_allocator_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_q),
    .request_size_i   (size_q),
    .free_class_i     (free_class_q),
    .free_batch_i     (free_batch_q),
    .free_offset_i    (free_offset_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .status_o         (status_o),
    .granted_class_o  (granted_class_o),
    .granted_batch_o  (granted_batch_o),
    .granted_offset_o (granted_offset_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, plus one long hold-off when asked for
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready)
      sb.check_result(status_o, granted_class_o, granted_batch_o, granted_offset_o);
  end

  // one request: hold valid until taken, predict, then maybe idle a while
  task automatic send_request(scsa_pkg::kind_e kind, int unsigned size, int unsigned cls,
                              int unsigned batch, int unsigned off);
    in_valid      <= 1'b1;
    kind_q        <= kind;
    size_q        <= size[scsa_pkg::SIZE_W-1:0];
    free_class_q  <= cls[scsa_pkg::CLASS_W-1:0];
    free_batch_q  <= batch[scsa_pkg::BATCH_W-1:0];
    free_offset_q <= off[scsa_pkg::OFFSET_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(kind, size, cls, batch, off);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_alloc(int unsigned size);
    send_request(scsa_pkg::KIND_ALLOC, size, $urandom_range(7), $urandom_range(3),
                 $urandom_range(1023));
  endtask

  task automatic send_free(int unsigned cls, int unsigned batch, int unsigned off);
    send_request(scsa_pkg::KIND_FREE, $urandom_range(255), cls, batch, off);
  endtask

  task automatic send_random();
    int unsigned r, cls, batch, off, slot_bytes;
    r = $urandom_range(99);
    if (burst_left > 0) begin
      // burst of one class, long enough to run into the batch limit
      burst_left--;
      send_alloc($urandom_range((burst_cls - 1) * scsa_pkg::GRANULE_BYTES + 1,
                                burst_cls * scsa_pkg::GRANULE_BYTES));
    end else if (r < 45) begin
      r = $urandom_range(99);
      if (r < 3) begin
        burst_cls  = $urandom_range(1, scsa_pkg::NUM_CLASSES);
        burst_left = SLOTS_PER_CLASS + 3;
        send_alloc($urandom_range(1, scsa_pkg::GRANULE_BYTES * scsa_pkg::NUM_CLASSES));
      end else if (r < 85) begin
        send_alloc($urandom_range(1, scsa_pkg::GRANULE_BYTES * scsa_pkg::NUM_CLASSES));
      end else if (r < 90) begin
        send_alloc(0);
      end else begin
        send_alloc($urandom_range(scsa_pkg::GRANULE_BYTES * scsa_pkg::NUM_CLASSES + 1, 255));
      end
    end else if (r < 80) begin
      if (sb.pick_slot(1'b0, cls, batch, off)) send_free(cls, batch, off);
      else send_alloc($urandom_range(1, scsa_pkg::GRANULE_BYTES * scsa_pkg::NUM_CLASSES));
    end else if (r < 88) begin
      // misaligned free inside the class range
      cls        = $urandom_range(1, scsa_pkg::NUM_CLASSES);
      slot_bytes = cls * scsa_pkg::GRANULE_BYTES;
      off        = $urandom_range(scsa_pkg::SLOTS_PER_BATCH - 1) * slot_bytes
                   + $urandom_range(1, slot_bytes - 1);
      send_free(cls, $urandom_range(3), off);
    end else if (r < 94) begin
      if (sb.pick_slot(1'b1, cls, batch, off)) send_free(cls, batch, off);
      else send_free($urandom_range(7), $urandom_range(3), $urandom_range(1023));
    end else begin
      send_free($urandom_range(7), $urandom_range(3), $urandom_range(1023));
    end
  endtask

  initial begin
    int unsigned guard;
    sb            = new();
    tx_idle_pct   = 21;
    rx_idle_pct   = 87;
    hold_go       = 1'b0;
    burst_left    = 0;
    burst_cls     = 1;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    kind_q        <= scsa_pkg::KIND_ALLOC;
    size_q        <= '0;
    free_class_q  <= '0;
    free_batch_q  <= '0;
    free_offset_q <= '0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed corners: size rounding, every class, every free failure
    send_alloc(0);
    send_alloc(1);
    send_alloc(16);
    send_alloc(17);
    send_alloc(80);
    send_alloc(81);
    send_alloc(255);
    send_alloc(33);
    send_alloc(64);
    send_alloc(48);
    send_free(0, 0, 0);
    send_free(6, 0, 0);
    send_free(7, 3, 1023);
    send_free(1, 1, 0);
    send_free(1, 0, scsa_pkg::SLOTS_PER_BATCH * scsa_pkg::GRANULE_BYTES);
    send_free(3, 0, 1023);
    send_free(2, 0, 16);
    send_free(1, 0, 32);
    send_free(1, 0, 16);
    send_free(1, 0, 16);
    send_free(5, 0, 560);
    send_free(5, 0, 0);
    send_free(4, 3, 0);
    send_free(2, 0, 0);
    send_alloc(128);

    // sender idles a little, receiver a lot
    repeat (PHASE_ITEMS) send_random();
    tx_idle_pct = 87;
    rx_idle_pct = 21;
    repeat (PHASE_ITEMS) send_random();
    // full rate, with one long result stall to fill the pipeline
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go     = 1'b1;
    repeat (PHASE_ITEMS) send_random();
    in_valid <= 1'b0;

    guard = 0;
    while (sb.pending_grants.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending_grants.size() != 0) begin
      $error("%0d results never arrived", sb.pending_grants.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/scsa_pkg.sv
src/scsa_front.sv
src/scsa_fifo.sv
src/scsa_back.sv
src/size_class_slot_allocator_core.sv
tb/tb_size_class_slot_allocator_core.sv
